// ===== hdl/csalu_pkg.sv =====
// ----------------------------------------------------------------------------
// csalu_pkg
// Types and constants for the overflow-checked 64-bit signed ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package csalu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = DATA_W / 2;
    localparam int unsigned DIV_STAGES = DATA_W;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hdl/checked_signed_alu_top.sv =====
// ----------------------------------------------------------------------------
// checked_signed_alu_top
// Overflow-checked 64-bit signed add, subtract, multiply and divide.
// Every op takes the same path through the pipe, from the accepting edge to the result strobe.
// Throughput: one request per cycle; busy is never raised.
// The divider is a 64-stage restoring pipeline, one quotient bit per stage.
// The multiplier uses four 32x32 products, summed over two further stages.
// Reset (synchronous, active low) clears all valid bits; no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_signed_alu_top
    import csalu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam logic [63:0] MIN_S = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [63:0] MAX_S = {1'b0, {(DATA_W-1){1'b1}}};

    logic accept;
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // stage 0: magnitudes, add/sub, division special cases
    logic [63:0] n_mag_a, n_mag_b, n_sum, n_dif;
    logic        n_ok0, n_neg0;
    logic [63:0] n_res0;

    always_comb begin
        n_mag_a = i_req.operand_a[63] ? (64'd0 - i_req.operand_a) : i_req.operand_a;
        n_mag_b = i_req.operand_b[63] ? (64'd0 - i_req.operand_b) : i_req.operand_b;
        n_sum   = i_req.operand_a + i_req.operand_b;
        n_dif   = i_req.operand_a - i_req.operand_b;
        n_neg0  = i_req.operand_a[63] ^ i_req.operand_b[63];
        n_res0  = '0;
        case (i_req.cmd)
            CMD_ADD: begin
                n_ok0  = !(!n_neg0 && (n_sum[63] != i_req.operand_a[63]));
                n_res0 = n_ok0 ? n_sum : 64'd0;
            end
            CMD_SUB: begin
                n_ok0  = !(n_neg0 && (n_dif[63] != i_req.operand_a[63]));
                n_res0 = n_ok0 ? n_dif : 64'd0;
            end
            CMD_MUL: n_ok0 = 1'b1;
            CMD_DIV: n_ok0 = !((i_req.operand_b == 64'd0) ||
                               (i_req.operand_a == MIN_S && i_req.operand_b == '1));
            default: n_ok0 = 1'b0;
        endcase
    end

    // common pipe, index k is the state after k division steps
    logic        r_v   [0:DIV_STAGES];
    t_cmd        r_cmd [0:DIV_STAGES];
    logic [63:0] r_res [0:DIV_STAGES];
    logic        r_ok  [0:DIV_STAGES];
    logic        r_neg [0:DIV_STAGES];
    logic [63:0] r_rem [0:DIV_STAGES];
    logic [63:0] r_quo [0:DIV_STAGES];
    logic [63:0] r_dvs [0:DIV_STAGES];

    logic [63:0] n_rem [1:DIV_STAGES];
    logic [63:0] n_quo [1:DIV_STAGES];
    logic [63:0] n_res [1:DIV_STAGES];
    logic        n_ok  [1:DIV_STAGES];

    // multiplier side registers, aligned with pipe indexes 1..3
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [63:0] r_mid, r_hs;
    logic [31:0] r_p00_lo;
    logic [63:0] r_lo, r_hi;
    logic        n_mul_ok;
    logic [63:0] n_mul_res;

    always_comb begin
        n_mul_ok  = (r_hi == 64'd0) &&
                    (r_neg[3] ? (r_lo <= MIN_S) : (r_lo <= MAX_S));
        n_mul_res = n_mul_ok ? (r_neg[3] ? (64'd0 - r_lo) : r_lo) : 64'd0;
    end

    always_comb begin
        logic [63:0] sh;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            sh = {r_rem[k-1][62:0], r_quo[k-1][63]};
            if (sh >= r_dvs[k-1]) begin
                n_rem[k] = sh - r_dvs[k-1];
                n_quo[k] = {r_quo[k-1][62:0], 1'b1};
            end else begin
                n_rem[k] = sh;
                n_quo[k] = {r_quo[k-1][62:0], 1'b0};
            end
            if (k == 4 && r_cmd[3] == CMD_MUL) begin
                n_res[k] = n_mul_res;
                n_ok[k]  = n_mul_ok;
            end else begin
                n_res[k] = r_res[k-1];
                n_ok[k]  = r_ok[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= accept;
            for (int k = 1; k <= DIV_STAGES; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd[0] <= i_req.cmd;
        r_res[0] <= n_res0;
        r_ok[0]  <= n_ok0;
        r_neg[0] <= n_neg0;
        r_rem[0] <= '0;
        r_quo[0] <= n_mag_a;
        r_dvs[0] <= n_mag_b;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            r_cmd[k] <= r_cmd[k-1];
            r_neg[k] <= r_neg[k-1];
            r_dvs[k] <= r_dvs[k-1];
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_res[k] <= n_res[k];
            r_ok[k]  <= n_ok[k];
        end
        r_p00 <= r_quo[0][HALF_W-1:0]      * r_dvs[0][HALF_W-1:0];
        r_p01 <= r_quo[0][HALF_W-1:0]      * r_dvs[0][DATA_W-1:HALF_W];
        r_p10 <= r_quo[0][DATA_W-1:HALF_W] * r_dvs[0][HALF_W-1:0];
        r_p11 <= r_quo[0][DATA_W-1:HALF_W] * r_dvs[0][DATA_W-1:HALF_W];
        r_mid <= {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
        r_hs  <= r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]};
        r_p00_lo <= r_p00[31:0];
        r_lo  <= {r_mid[31:0], r_p00_lo};
        r_hi  <= r_hs + {32'd0, r_mid[63:32]};
    end

    // output stage: signed quotient for divides
    logic [63:0] last_q;
    assign last_q = r_neg[DIV_STAGES] ? (64'd0 - r_quo[DIV_STAGES]) : r_quo[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        o_rsp.ok <= r_ok[DIV_STAGES];
        if (r_cmd[DIV_STAGES] == CMD_DIV) begin
            o_rsp.value <= r_ok[DIV_STAGES] ? last_q : 64'd0;
        end else begin
            o_rsp.value <= r_res[DIV_STAGES];
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, DIV_STAGES + 2))
        else $error("result strobe without matching request");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.ok) |-> (o_rsp.value == 64'd0))
        else $error("failed result carries nonzero value");
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_cmd[0] == CMD_DIV && r_dvs[0] == 64'd0) |-> !r_ok[0])
        else $error("zero divisor not flagged");

endmodule

`default_nettype wire
